// File: sv/pidc_pkg.sv
// shared types, codes and helpers for the three-mode pid controller
`timescale 1ns / 1ps

package pidc_pkg;

	// request codes carried by req_type
	localparam logic REQ_STEP  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// controller modes; the unused code behaves as incremental without accumulation
	typedef enum logic [1:0] {
		MODE_POSITIONAL = 2'd0,
		MODE_INC_ACC    = 2'd1,
		MODE_INC_NOACC  = 2'd2
	} pidc_mode_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd5;

	localparam int SAMPLE_W = 16;
	localparam int ERR_W    = 17;
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 31;
	localparam int DRIVE_W  = 32;
	// wide enough for any shifted product plus integral plus previous drive
	localparam int SUM_W    = 40;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [GAIN_W-1:0]   gain_p;
		logic signed [GAIN_W-1:0]   gain_i;
		logic signed [GAIN_W-1:0]   gain_d;
		logic [LIMIT_W-1:0]         int_limit;
		logic [LIMIT_W-1:0]         out_limit;
	} pidc_cfg_t;

	// symmetric clamp of a wide signed sum to +/- lim
	function automatic logic signed [DRIVE_W-1:0] pidc_clamp(
		input logic signed [SUM_W-1:0] v,
		input logic [LIMIT_W-1:0]      lim
	);
		logic signed [SUM_W-1:0] pos_lim;
		logic signed [SUM_W-1:0] neg_lim;
		logic signed [SUM_W-1:0] res;
		pos_lim = signed'({{(SUM_W-LIMIT_W){1'b0}}, lim});
		neg_lim = -pos_lim;
		if (v > pos_lim) begin
			res = pos_lim;
		end else if (v < neg_lim) begin
			res = neg_lim;
		end else begin
			res = v;
		end
		return res[DRIVE_W-1:0];
	endfunction

endpackage

// File: sv/pidc_cfg.sv
// configuration register file for the pid controller
`timescale 1ns / 1ps

module pidc_cfg
	import pidc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pidc_cfg_t             cfg
);

	pidc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:      cfg_q.mode      <= cfg_data[1:0];
				CFG_GAIN_P:    cfg_q.gain_p    <= signed'(cfg_data[GAIN_W-1:0]);
				CFG_GAIN_I:    cfg_q.gain_i    <= signed'(cfg_data[GAIN_W-1:0]);
				CFG_GAIN_D:    cfg_q.gain_d    <= signed'(cfg_data[GAIN_W-1:0]);
				CFG_INT_LIMIT: cfg_q.int_limit <= cfg_data[LIMIT_W-1:0];
				CFG_OUT_LIMIT: cfg_q.out_limit <= cfg_data[LIMIT_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// File: sv/pidc_core.sv
// pid datapath and controller state: errors, integral term, last drive
`timescale 1ns / 1ps

module pidc_core
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       req_type,
	input  logic signed [SAMPLE_W-1:0] feedback,
	input  logic signed [SAMPLE_W-1:0] target,
	input  pidc_cfg_t                  cfg,
	output logic signed [DRIVE_W-1:0]  drive
);

	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [ERR_W-1:0]   pprev_err_q;
	logic signed [DRIVE_W-1:0] integ_q;
	logic signed [DRIVE_W-1:0] prev_drive_q;

	logic positional;
	logic accumulate;

	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W:0]     diff1;
	logic signed [ERR_W+1:0]   diff2;
	logic signed [ERR_W:0]     p_opnd;
	logic signed [ERR_W+1:0]   d_opnd;

	logic signed [GAIN_W+ERR_W:0]   p_prod;
	logic signed [GAIN_W+ERR_W-1:0] i_prod;
	logic signed [GAIN_W+ERR_W+1:0] d_prod;

	logic signed [SUM_W-1:0]   p_term;
	logic signed [SUM_W-1:0]   i_inc;
	logic signed [SUM_W-1:0]   d_term;
	logic signed [SUM_W-1:0]   i_sum;
	logic signed [DRIVE_W-1:0] iterm;
	logic signed [SUM_W-1:0]   drive_sum;
	logic signed [DRIVE_W-1:0] drive_clamped;

	assign positional = (cfg.mode == MODE_POSITIONAL);
	assign accumulate = (cfg.mode == MODE_INC_ACC);

	// error and its first and second differences
	assign err   = ERR_W'(target) - ERR_W'(feedback);
	assign diff1 = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_q);
	assign diff2 = (ERR_W+2)'(err) - ((ERR_W+2)'(prev_err_q) <<< 1)
		+ (ERR_W+2)'(pprev_err_q);

	// positional uses e and de, incremental uses de and d2e
	assign p_opnd = positional ? (ERR_W+1)'(err) : diff1;
	assign d_opnd = positional ? (ERR_W+2)'(diff1) : diff2;

	assign p_prod = cfg.gain_p * p_opnd;
	assign i_prod = cfg.gain_i * err;
	assign d_prod = cfg.gain_d * d_opnd;

	// floor shift by the gain fraction width
	assign p_term = SUM_W'(p_prod) >>> GAIN_FRAC_BITS;
	assign i_inc  = SUM_W'(i_prod) >>> GAIN_FRAC_BITS;
	assign d_term = SUM_W'(d_prod) >>> GAIN_FRAC_BITS;

	assign i_sum = (positional ? SUM_W'(integ_q) : '0) + i_inc;
	assign iterm = pidc_clamp(i_sum, cfg.int_limit);

	assign drive_sum = p_term + SUM_W'(iterm) + d_term
		+ (accumulate ? SUM_W'(prev_drive_q) : '0);
	assign drive_clamped = pidc_clamp(drive_sum, cfg.out_limit);

	assign drive = (req_type == REQ_CLEAR) ? '0 : drive_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			pprev_err_q  <= '0;
			integ_q      <= '0;
			prev_drive_q <= '0;
		end else if (step) begin
			if (req_type == REQ_CLEAR) begin
				prev_err_q   <= '0;
				pprev_err_q  <= '0;
				integ_q      <= '0;
				prev_drive_q <= '0;
			end else begin
				prev_err_q <= err;
				integ_q    <= iterm;
				if (!positional) begin
					pprev_err_q <= prev_err_q;
				end
				if (accumulate) begin
					prev_drive_q <= drive_clamped;
				end
			end
		end
	end

endmodule

// File: sv/pid_controller_three_mode_top.sv
// top level of the three-mode pid controller: handshakes, input and result registers
`timescale 1ns / 1ps

// channel   signals                                    direction
// in        in_valid, in_stall, req_type, feedback,    beat into the block
//           target
// out       out_valid, out_stall, drive                beat out of the block
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  register write beat
//
// each beat passes from acceptance through the input register, where the whole pid
// step is worked out, and then through the result register
// one beat can enter every cycle unless in_stall is high; the controller state
// updates as a beat leaves the input register, so the next beat sees it at once
// reset clears the state, configuration registers and valid flags; cfg_ready is always high
// out_stall on a full result register holds both registers and raises in_stall
// while the input register is full

module pid_controller_three_mode_top
	import pidc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input beat
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic signed [SAMPLE_W-1:0] feedback,
	input  logic signed [SAMPLE_W-1:0] target,
	// result beat
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DRIVE_W-1:0]  drive,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	pidc_cfg_t cfg;

	// input register
	logic                       valid_s1;
	logic                       req_type_s1;
	logic signed [SAMPLE_W-1:0] feedback_s1;
	logic signed [SAMPLE_W-1:0] target_s1;

	// result register
	logic                       valid_s2;
	logic signed [DRIVE_W-1:0]  drive_s2;

	logic                       advance;
	logic                       move;
	logic                       accept;
	logic signed [DRIVE_W-1:0]  drive_comb;

	pidc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register can take a new beat when empty or being drained
	assign advance  = !valid_s2 || !out_stall;
	// a beat leaves the input register and commits its state update
	assign move     = valid_s1 && advance;
	// input register is free unless it holds a beat that cannot move on
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	pidc_core #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (move),
		.req_type (req_type_s1),
		.feedback (feedback_s1),
		.target   (target_s1),
		.cfg      (cfg),
		.drive    (drive_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			feedback_s1 <= feedback;
			target_s1   <= target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			drive_s2 <= drive_comb;
		end
	end

	assign out_valid = valid_s2;
	assign drive     = drive_s2;

endmodule

// File: dv/pid_controller_three_mode_checker.sv
// checker for the three-mode pid controller: predicts each drive beat and compares it
`timescale 1ns / 1ps

module pid_controller_three_mode_checker
	import pidc_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       req_type,
	input  logic signed [SAMPLE_W-1:0] feedback,
	input  logic signed [SAMPLE_W-1:0] target,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [DRIVE_W-1:0]  drive,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         fail_count,
	output int                         drives_checked,
	output int                         drives_pending
);

	// register copy
	logic [1:0]               cfg_mode;
	logic signed [GAIN_W-1:0] kp;
	logic signed [GAIN_W-1:0] ki;
	logic signed [GAIN_W-1:0] kd;
	logic [LIMIT_W-1:0]       int_limit;
	logic [LIMIT_W-1:0]       out_limit;

	// controller state copy, held wide
	longint err_last;
	longint err_older;
	longint integ_held;
	longint drive_held;

	logic signed [DRIVE_W-1:0] drive_expect_q[$];
	logic signed [DRIVE_W-1:0] drive_expect;

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	// one controller step; updates the state copy and returns the drive value
	function automatic longint predict_drive(
		input logic                 rq,
		input logic [SAMPLE_W-1:0]  fb,
		input logic [SAMPLE_W-1:0]  tg
	);
		longint err;
		longint iterm;
		longint sum;
		longint lim_i;
		longint lim_o;
		lim_i = longint'(int_limit);
		lim_o = longint'(out_limit);
		if (rq == REQ_CLEAR) begin
			err_last   = 0;
			err_older  = 0;
			integ_held = 0;
			drive_held = 0;
			return 0;
		end
		err = longint'($signed(tg)) - longint'($signed(fb));
		if (cfg_mode == MODE_POSITIONAL) begin
			iterm = clamp_sym(integ_held + ((longint'(ki) * err) >>> FRAC_BITS), lim_i);
			sum = ((longint'(kp) * err) >>> FRAC_BITS) + iterm
				+ ((longint'(kd) * (err - err_last)) >>> FRAC_BITS);
			sum = clamp_sym(sum, lim_o);
			integ_held = iterm;
			err_last   = err;
		end else begin
			iterm = clamp_sym((longint'(ki) * err) >>> FRAC_BITS, lim_i);
			sum = ((longint'(kp) * (err - err_last)) >>> FRAC_BITS) + iterm
				+ ((longint'(kd) * (err - 2 * err_last + err_older)) >>> FRAC_BITS);
			// the unused mode code falls through to no accumulation
			if (cfg_mode == MODE_INC_ACC) begin
				sum = clamp_sym(sum + drive_held, lim_o);
				drive_held = sum;
			end else begin
				sum = clamp_sym(sum, lim_o);
			end
			integ_held = iterm;
			err_older  = err_last;
			err_last   = err;
		end
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode   = MODE_POSITIONAL;
			kp         = '0;
			ki         = '0;
			kd         = '0;
			int_limit  = '0;
			out_limit  = '0;
			err_last   = 0;
			err_older  = 0;
			integ_held = 0;
			drive_held = 0;
			drive_expect_q.delete();
			drives_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:      cfg_mode  = cfg_data[1:0];
					CFG_GAIN_P:    kp        = cfg_data[GAIN_W-1:0];
					CFG_GAIN_I:    ki        = cfg_data[GAIN_W-1:0];
					CFG_GAIN_D:    kd        = cfg_data[GAIN_W-1:0];
					CFG_INT_LIMIT: int_limit = cfg_data[LIMIT_W-1:0];
					CFG_OUT_LIMIT: out_limit = cfg_data[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (drive_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: drive beat %0d with no beat waiting", $realtime, drive);
					end
				end else begin
					drive_expect = drive_expect_q.pop_front();
					drives_checked++;
					if (drive !== drive_expect) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: drive mismatch, expected %0d, got %0d",
								$realtime, drive_expect, drive);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				drive_expect_q.push_back(DRIVE_W'(predict_drive(req_type, feedback, target)));
			end
			drives_pending <= drive_expect_q.size();
		end
	end

endmodule

// File: dv/tb_pid_controller_three_mode_top.sv
// testbench top for the three-mode pid controller: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_pid_controller_three_mode_top;
	import pidc_pkg::*;

	localparam int FRAC_BITS       = 8;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 140;

	// the mode code the package leaves unnamed; it must act as no accumulation
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// first index past the register file
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_OUT_LIMIT + 1);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [GAIN_W-1:0]   GAIN_MIN   = 16'h8000;
	localparam logic [GAIN_W-1:0]   GAIN_MAX   = 16'h7FFF;
	localparam logic [LIMIT_W-1:0]  LIMIT_MAX  = 31'h7FFFFFFF;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic                       req_type  = REQ_STEP;
	logic signed [SAMPLE_W-1:0] feedback  = '0;
	logic signed [SAMPLE_W-1:0] target    = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [DRIVE_W-1:0]  drive;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	int fail_count;
	int drives_checked;
	int drives_pending;

	// pacing: sender gap chance, receiver stall chance, long hold requests
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int          hold_req  = 0;

	int cycle_count  = 0;
	int beats_sent   = 0;
	int settings_done = 0;

	always #5 clk = ~clk;

	pid_controller_three_mode_top #(
		.GAIN_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.feedback  (feedback),
		.target    (target),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// watches all three channels and keeps its own copy of the controller
	pid_controller_three_mode_checker #(
		.FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.feedback       (feedback),
		.target         (target),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive          (drive),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.drives_checked (drives_checked),
		.drives_pending (drives_pending)
	);

	// run limit, far above the slowest correct run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d drive beats still waiting",
			cycle_count, drives_pending);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, or a long hold when one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// offer one input beat, with a random gap first, and wait until it is taken
	task automatic send_beat(
		input logic                rq,
		input logic [SAMPLE_W-1:0] fb,
		input logic [SAMPLE_W-1:0] tg
	);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		feedback <= fb;
		target   <= tg;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		beats_sent++;
	endtask

	// one register write beat; valid drops for a cycle afterwards
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// write every register; unused data bits carry noise, and a spare index is poked
	task automatic configure(
		input logic [1:0]         m,
		input logic [GAIN_W-1:0]  gp,
		input logic [GAIN_W-1:0]  gi,
		input logic [GAIN_W-1:0]  gd,
		input logic [LIMIT_W-1:0] il,
		input logic [LIMIT_W-1:0] ol
	);
		logic [CFG_DATA_W-1:0] data;
		data = $urandom();
		data[1:0] = m;
		cfg_write(CFG_MODE, data);
		data = $urandom();
		data[GAIN_W-1:0] = gp;
		cfg_write(CFG_GAIN_P, data);
		data = $urandom();
		data[GAIN_W-1:0] = gi;
		cfg_write(CFG_GAIN_I, data);
		data = $urandom();
		data[GAIN_W-1:0] = gd;
		cfg_write(CFG_GAIN_D, data);
		data = $urandom();
		data[LIMIT_W-1:0] = il;
		cfg_write(CFG_INT_LIMIT, data);
		data = $urandom();
		data[LIMIT_W-1:0] = ol;
		cfg_write(CFG_OUT_LIMIT, data);
		// out-of-range index, must leave every register alone
		cfg_write(CFG_IDX_W'(CFG_IDX_SPARE + $urandom_range(0, 1)), $urandom());
		settings_done++;
	endtask

	// stop offering, wait out every drive beat, then a further drain margin
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (drives_pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] extreme_sample();
		case ($urandom_range(0, 3))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// gains lean on the signed extremes and near-unity values
	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return GAIN_MIN;
			1: return GAIN_MAX;
			2: return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	// limits: zero, the maximum, small, medium or anything
	function automatic logic [LIMIT_W-1:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LIMIT_MAX;
			2: return LIMIT_W'($urandom_range(0, 2000));
			3: return LIMIT_W'($urandom_range(0, 1 << 20));
			default: return LIMIT_W'($urandom());
		endcase
	endfunction

	initial begin
		int pick;
		int set_point;
		int spread;
		int sample;

		// reset, held low from the start, then released at an edge
		repeat (3) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 36;
		stall_pct <= 87;

		// directed: positional mode, full-scale errors in both directions and a clear
		configure(MODE_POSITIONAL, 16'd256, 16'd64, 16'hFF80, 31'd5000, LIMIT_MAX);
		send_beat(REQ_STEP, 16'd0, 16'd100);
		send_beat(REQ_STEP, SAMPLE_MIN, SAMPLE_MAX);
		send_beat(REQ_STEP, SAMPLE_MAX, SAMPLE_MIN);
		send_beat(REQ_STEP, 16'd0, 16'd0);
		send_beat(REQ_CLEAR, 16'd1234, 16'hABCD);
		send_beat(REQ_STEP, 16'd10, 16'hFFF6);
		wait_drained();

		// directed: accumulating incremental mode, drive builds up, then a clear
		configure(MODE_INC_ACC, 16'd256, 16'd32, 16'd16, 31'd100000, 31'd1000000);
		send_beat(REQ_STEP, 16'd0, 16'd1000);
		send_beat(REQ_STEP, 16'd0, 16'd1000);
		send_beat(REQ_STEP, 16'd0, 16'd1000);
		send_beat(REQ_STEP, SAMPLE_MAX, SAMPLE_MIN);
		send_beat(REQ_CLEAR, SAMPLE_MAX, SAMPLE_MAX);
		send_beat(REQ_STEP, 16'd5, 16'd5);
		wait_drained();

		// directed: no accumulation with extreme gains and the widest limits
		configure(MODE_INC_NOACC, GAIN_MIN, GAIN_MAX, GAIN_MIN, LIMIT_MAX, LIMIT_MAX);
		send_beat(REQ_STEP, SAMPLE_MIN, SAMPLE_MAX);
		send_beat(REQ_STEP, SAMPLE_MAX, SAMPLE_MIN);
		send_beat(REQ_STEP, 16'd1, 16'd2);
		wait_drained();

		// directed: unused mode code, zero limits force the drive to zero
		configure(MODE_UNUSED, GAIN_MAX, GAIN_MAX, GAIN_MAX, '0, '0);
		send_beat(REQ_STEP, 16'd100, 16'hFF9C);
		send_beat(REQ_STEP, 16'hFF9C, 16'd100);
		wait_drained();

		// directed: zero integral limit only, output free
		configure(MODE_UNUSED, GAIN_MAX, GAIN_MAX, GAIN_MIN, '0, LIMIT_MAX);
		send_beat(REQ_STEP, SAMPLE_MIN, SAMPLE_MAX);
		send_beat(REQ_STEP, 16'd7, 16'd3);
		wait_drained();

		// random phases: busy receiver, then slow sender, then full rate
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < NUM_PHASES / 3) begin
				idle_pct  = 36;
				stall_pct <= 87;
			end else if (ph < 2 * NUM_PHASES / 3) begin
				idle_pct  = 87;
				stall_pct <= 36;
			end else begin
				idle_pct  = 0;
				stall_pct <= 0;
			end
			configure(2'($urandom_range(0, 3)), rand_gain(), rand_gain(), rand_gain(),
				rand_limit(), rand_limit());
			set_point = int'($urandom_range(0, 60000)) - 30000;
			spread    = int'($urandom_range(1, 2000));
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// receiver holds off for a long stretch while the sender keeps going
				if (ph == NUM_PHASES - 3 && k == 20) begin
					hold_req <= hold_req + 1;
				end
				// sender pauses until every drive beat is back
				if ((ph == 5 || ph == NUM_PHASES - 2) && k == ITEMS_PER_PHASE / 2) begin
					wait_drained();
				end
				pick = int'($urandom_range(0, 99));
				if (pick < 3) begin
					send_beat(REQ_CLEAR, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
				end else if (pick < 13) begin
					send_beat(REQ_STEP, extreme_sample(), extreme_sample());
				end else if (pick < 38) begin
					send_beat(REQ_STEP, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
				end else begin
					// loop tracking a set point, with the odd step change
					if (pick < 42) begin
						set_point = int'($urandom_range(0, 60000)) - 30000;
					end
					sample = set_point + int'($urandom_range(0, 2 * spread)) - spread;
					if (sample > 32767) begin
						sample = 32767;
					end
					if (sample < -32768) begin
						sample = -32768;
					end
					send_beat(REQ_STEP, SAMPLE_W'(sample), SAMPLE_W'(set_point));
				end
			end
			wait_drained();
		end

		$display("covered %0d input beats over %0d register settings, %0d drive beats checked",
			beats_sent, settings_done, drives_checked);
		$display("all three modes plus the unused code, clears, extreme gains and limits, %0d cycles",
			cycle_count);
		if (fail_count == 0 && drives_pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures, %0d drive beats never arrived", fail_count, drives_pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: pid_controller_three_mode_top.f
sv/pidc_pkg.sv
sv/pidc_cfg.sv
sv/pidc_core.sv
sv/pid_controller_three_mode_top.sv
dv/pid_controller_three_mode_checker.sv
dv/tb_pid_controller_three_mode_top.sv
